// ===== sv/bti_pkg.sv =====
// ----------------------------------------------------------------------------
// bti_pkg
// Types and codes shared by the breakpoint table interpolation block.
// ----------------------------------------------------------------------------
package bti_pkg;

  localparam int POINTS_DEFAULT = 256;

  localparam logic [1:0] OP_LOAD      = 2'd0;
  localparam logic [1:0] OP_EVAL      = 2'd1;
  localparam logic [1:0] OP_INTEGRATE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_INDEX     = 2'd1;
  localparam logic [1:0] ST_REVERSED  = 2'd2;
  localparam logic [1:0] ST_SATURATED = 2'd3;

  typedef struct packed {
    logic        [1:0]  opcode;
    logic        [7:0]  point_index;
    logic        [31:0] time_a;
    logic        [31:0] time_b;
    logic signed [31:0] load_value;
  } req_t;

  typedef struct packed {
    logic signed [63:0] result_value;
    logic        [1:0]  status;
  } rsp_t;

endpackage

// ===== sv/breakpoint_table_interp_integrate.sv =====
// ----------------------------------------------------------------------------
// breakpoint_table_interp_integrate
// Breakpoint table with piecewise linear evaluation and trapezoid integral.
// ----------------------------------------------------------------------------
// latency depends on the opcode: load and unused opcodes go straight to the response;
// evaluate gives an end value if clamped, else scans, multiplies, 64-step divides
// integrate: evaluates at each cut point, checks each entry, multiply-adds each piece
// one request in flight at a time; the serial divider and the single memory port set it
// reset: control idle, point_count 1, table contents undefined until loaded
module breakpoint_table_interp_integrate #(
  parameter int POINTS = bti_pkg::POINTS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  bti_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output bti_pkg::rsp_t rsp,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [8:0]    cfg_data
);

  localparam int AW = $clog2(POINTS);
  localparam int CW = $clog2(POINTS + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD0   = 4'd1;
  localparam logic [3:0] S_RDL   = 4'd2;
  localparam logic [3:0] S_CHK0  = 4'd3;
  localparam logic [3:0] S_SCAN  = 4'd4;
  localparam logic [3:0] S_MUL   = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_ADD   = 4'd7;
  localparam logic [3:0] S_ILOOP = 4'd8;
  localparam logic [3:0] S_ICHK  = 4'd9;
  localparam logic [3:0] S_IMUL  = 4'd10;
  localparam logic [3:0] S_IACC  = 4'd11;
  localparam logic [3:0] S_ISAT  = 4'd12;
  localparam logic [3:0] S_FIN   = 4'd13;

  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_PIECE = 2'd1;
  localparam logic [1:0] PH_LAST  = 2'd2;

  logic [63:0] mem [POINTS];
  logic [63:0] rdata;
  logic [AW-1:0] ra;

  logic [3:0]  state;
  logic [1:0]  op;
  logic [1:0]  phase;
  logic [8:0]  point_count;
  logic [31:0] ta, tb, qt, prev, cut_t;
  logic [31:0] lo_t, hi_t;
  logic signed [31:0] lo_v, hi_v, vprev, vk;
  logic [CW-1:0] idx, k;
  logic [63:0] dvd;
  logic [32:0] rem, span;
  logic        neg;
  logic [6:0]  cnt;
  logic signed [65:0] prod;
  logic signed [67:0] acc;
  logic signed [63:0] res;
  logic [1:0]  status;

  logic [31:0]   pc32, idx32;
  logic [CW-1:0] n, n_m1, idx_p1;
  logic [32:0]   r2;
  logic signed [32:0] d;
  logic [32:0]   mag;
  logic [64:0]   pmag;
  logic signed [33:0] sum34;
  logic signed [31:0] ev;
  logic [31:0]   w;
  logic signed [32:0] sumv;
  logic signed [66:0] half;

  assign cfg_ready = 1'b1;
  assign req_stall = (state != S_IDLE);

  always_comb begin
    pc32 = {23'b0, point_count};
    if (pc32 == 32'd0) begin
      n = CW'(1);
    end else if (pc32 > 32'(POINTS)) begin
      n = CW'(POINTS);
    end else begin
      n = pc32[CW-1:0];
    end
    n_m1   = n - CW'(1);
    idx_p1 = idx + CW'(1);
    idx32  = {24'b0, req.point_index};
    r2     = {rem[31:0], dvd[63]};
    d      = 33'(hi_v) - 33'(lo_v);
    mag    = d[32] ? 33'(-d) : d;
    pmag   = {33'b0, qt - lo_t} * {32'b0, mag};
    sum34  = neg ? 34'(lo_v) - $signed({1'b0, dvd[32:0]})
                 : 34'(lo_v) + $signed({1'b0, dvd[32:0]});
    ev     = sum34[31:0];
    w      = (phase == PH_LAST ? tb : cut_t) - prev;
    sumv   = 33'(vprev) + 33'(vk);
    half   = acc[67:1];
    unique case (state)
      S_RDL:   ra = n_m1[AW-1:0];
      S_CHK0:  ra = AW'(1);
      S_SCAN:  ra = idx_p1[AW-1:0];
      S_ILOOP: ra = k[AW-1:0];
      default: ra = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    rdata <= mem[ra];
    if (state == S_IDLE && req_valid && req.opcode == bti_pkg::OP_LOAD &&
        idx32 < 32'(POINTS)) begin
      mem[idx32[AW-1:0]] <= {req.time_a, req.load_value};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rsp_valid   <= 1'b0;
      point_count <= 9'd1;
    end else begin
      if (rsp_valid && !rsp_stall && state != S_FIN) begin
        rsp_valid <= 1'b0;
      end
      if (cfg_valid) begin
        point_count <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            op     <= req.opcode;
            ta     <= req.time_a;
            tb     <= req.time_b;
            qt     <= req.time_a;
            phase  <= PH_START;
            acc    <= '0;
            res    <= '0;
            status <= bti_pkg::ST_OK;
            state  <= S_FIN;
            if (req.opcode == bti_pkg::OP_LOAD) begin
              if (idx32 >= 32'(POINTS)) status <= bti_pkg::ST_INDEX;
            end else if (req.opcode == bti_pkg::OP_EVAL) begin
              state <= S_RD0;
            end else if (req.opcode == bti_pkg::OP_INTEGRATE) begin
              if (req.time_a > req.time_b) begin
                status <= bti_pkg::ST_REVERSED;
              end else begin
                state <= S_RD0;
              end
            end
          end
        end
        S_RD0: state <= S_RDL;
        S_RDL: begin
          lo_t  <= rdata[63:32];
          lo_v  <= rdata[31:0];
          state <= S_CHK0;
        end
        S_CHK0: begin
          idx <= CW'(1);
          if (n == CW'(1) || qt <= lo_t) begin
            hi_v <= lo_v;
            dvd  <= '0;
            neg  <= 1'b0;
            state <= S_ADD;
          end else if (qt >= rdata[63:32]) begin
            lo_v <= rdata[31:0];
            dvd  <= '0;
            neg  <= 1'b0;
            state <= S_ADD;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (idx < n_m1 && qt > rdata[63:32]) begin
            lo_t <= rdata[63:32];
            lo_v <= rdata[31:0];
            idx  <= idx_p1;
          end else begin
            hi_t  <= rdata[63:32];
            hi_v  <= rdata[31:0];
            state <= S_MUL;
          end
        end
        S_MUL: begin
          dvd   <= pmag[63:0];
          span  <= {1'b0, hi_t - lo_t};
          neg   <= d[32];
          rem   <= '0;
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (r2 >= span) begin
            rem <= r2 - span;
            dvd <= {dvd[62:0], 1'b1};
          end else begin
            rem <= r2;
            dvd <= {dvd[62:0], 1'b0};
          end
          cnt <= cnt + 7'd1;
          if (cnt == 7'd63) state <= S_ADD;
        end
        S_ADD: begin
          if (op == bti_pkg::OP_EVAL) begin
            res   <= 64'(ev);
            state <= S_FIN;
          end else if (phase == PH_START) begin
            vprev <= ev;
            prev  <= ta;
            k     <= '0;
            state <= S_ILOOP;
          end else begin
            vk    <= ev;
            state <= S_IMUL;
          end
        end
        S_ILOOP: begin
          if (k < n) begin
            state <= S_ICHK;
          end else begin
            qt    <= tb;
            phase <= PH_LAST;
            state <= S_RD0;
          end
        end
        S_ICHK: begin
          if (rdata[63:32] > prev && rdata[63:32] < tb) begin
            cut_t <= rdata[63:32];
            qt    <= rdata[63:32];
            phase <= PH_PIECE;
            state <= S_RD0;
          end else begin
            k     <= k + CW'(1);
            state <= S_ILOOP;
          end
        end
        S_IMUL: begin
          prod  <= 66'(sumv) * 66'($signed({1'b0, w}));
          state <= S_IACC;
        end
        S_IACC: begin
          acc <= acc + 68'(prod);
          if (phase == PH_LAST) begin
            state <= S_ISAT;
          end else begin
            prev  <= cut_t;
            vprev <= vk;
            k     <= k + CW'(1);
            state <= S_ILOOP;
          end
        end
        S_ISAT: begin
          if (half[66:63] == {4{half[63]}}) begin
            res <= half[63:0];
          end else begin
            res    <= half[66] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
            status <= bti_pkg::ST_SATURATED;
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp.result_value <= res;
            rsp.status       <= status;
            rsp_valid        <= 1'b1;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/bti_table_checker.sv =====
// ----------------------------------------------------------------------------
// bti_table_checker
// Watches the request, response and config channels of the breakpoint table
// block, keeps its own copy of the table and point count, predicts each
// response and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module bti_table_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_stall,
  input  bti_pkg::req_t req,
  input  logic          rsp_valid,
  input  logic          rsp_stall,
  input  bti_pkg::rsp_t rsp,
  input  logic          cfg_valid,
  input  logic          cfg_ready,
  input  logic [8:0]    cfg_data,
  output int            pending,
  output int            errors
);

  localparam int POINTS = bti_pkg::POINTS_DEFAULT;

  logic        [31:0] tick_tab  [POINTS];
  logic signed [31:0] value_tab [POINTS];
  logic        [8:0]  point_count;
  bti_pkg::rsp_t      expected_rsp [$];

  function automatic int used_points();
    int n;
    n = point_count;
    if (n < 1) n = 1;
    if (n > POINTS) n = POINTS;
    return n;
  endfunction

  function automatic longint interp_value(logic [31:0] t);
    int          n;
    int          i;
    logic [31:0] span;
    logic [31:0] dt;
    longint      v0;
    longint      d;
    logic [63:0] mag;
    logic [63:0] q;
    n = used_points();
    if (n == 1 || t <= tick_tab[0]) return longint'(value_tab[0]);
    if (t >= tick_tab[n-1]) return longint'(value_tab[n-1]);
    i = 1;
    while (i < n - 1 && t > tick_tab[i]) i++;
    span = tick_tab[i] - tick_tab[i-1];
    dt   = t - tick_tab[i-1];
    v0   = longint'(value_tab[i-1]);
    d    = longint'(value_tab[i]) - v0;
    mag  = (d < 0) ? 64'(-d) : 64'(d);
    q    = (64'(dt) * mag) / 64'(span);
    return (d < 0) ? v0 - longint'(q) : v0 + longint'(q);
  endfunction

  function automatic bti_pkg::rsp_t trapezoid_area(logic [31:0] a, logic [31:0] b);
    int                  n;
    logic [31:0]         prev;
    longint              vprev;
    longint              vk;
    logic signed [127:0] acc;
    logic signed [127:0] ps;
    logic signed [127:0] pw;
    logic signed [127:0] half;
    bti_pkg::rsp_t       r;
    n     = used_points();
    prev  = a;
    vprev = interp_value(a);
    acc   = '0;
    for (int k = 0; k < n; k++) begin
      if (tick_tab[k] > prev && tick_tab[k] < b) begin
        vk  = interp_value(tick_tab[k]);
        ps  = vprev + vk;
        pw  = {96'b0, tick_tab[k] - prev};
        acc = acc + ps * pw;
        prev  = tick_tab[k];
        vprev = vk;
      end
    end
    ps   = vprev + interp_value(b);
    pw   = {96'b0, b - prev};
    acc  = acc + ps * pw;
    half = acc >>> 1;
    if (half[127:63] != {65{half[63]}}) begin
      r.result_value = half[127] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
      r.status       = bti_pkg::ST_SATURATED;
    end else begin
      r.result_value = half[63:0];
      r.status       = bti_pkg::ST_OK;
    end
    return r;
  endfunction

  function automatic bti_pkg::rsp_t predict_rsp(bti_pkg::req_t q);
    bti_pkg::rsp_t r;
    r.result_value = '0;
    r.status       = bti_pkg::ST_OK;
    case (q.opcode)
      bti_pkg::OP_LOAD: begin
        if (int'(q.point_index) < POINTS) begin
          tick_tab[q.point_index]  = q.time_a;
          value_tab[q.point_index] = q.load_value;
        end else begin
          r.status = bti_pkg::ST_INDEX;
        end
      end
      bti_pkg::OP_EVAL: begin
        r.result_value = interp_value(q.time_a);
      end
      bti_pkg::OP_INTEGRATE: begin
        if (q.time_a > q.time_b) r.status = bti_pkg::ST_REVERSED;
        else r = trapezoid_area(q.time_a, q.time_b);
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  initial begin
    errors  = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    bti_pkg::rsp_t want;
    if (rst) begin
      point_count <= 9'd1;
      expected_rsp.delete();
      pending = 0;
    end else begin
      if (cfg_valid && cfg_ready) point_count <= cfg_data;
      if (req_valid && !req_stall) expected_rsp.push_back(predict_rsp(req));
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsp.size() == 0) begin
          report_mismatch("unexpected response", rsp.result_value, '0);
        end else begin
          want = expected_rsp.pop_front();
          if (rsp.result_value !== want.result_value)
            report_mismatch("result_value", rsp.result_value, want.result_value);
          if (rsp.status !== want.status)
            report_mismatch("status", 64'(rsp.status), 64'(want.status));
        end
      end
      pending = expected_rsp.size();
    end
  end

endmodule

// ===== tb/breakpoint_table_interp_integrate_tb.sv =====
// ----------------------------------------------------------------------------
// breakpoint_table_interp_integrate_tb
// Drives loads, evaluations, integrals and unused opcodes into the breakpoint table block
// over several point counts and idle patterns; a checker beside the block
// predicts and compares every response.
// ----------------------------------------------------------------------------
module breakpoint_table_interp_integrate_tb;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic          clk;
  logic          rst;
  logic          req_valid;
  logic          req_stall;
  bti_pkg::req_t req;
  logic          rsp_valid;
  logic          rsp_stall;
  bti_pkg::rsp_t rsp;
  logic          cfg_valid;
  logic          cfg_ready;
  logic [8:0]    cfg_data;
  int            pending;
  int            errors;
  int            sender_idle;
  int            recv_stall;

  logic [31:0] tick_copy [256];

  breakpoint_table_interp_integrate dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  bti_table_checker table_check (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .pending(pending), .errors(errors)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #60000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(negedge clk) rsp_stall <= ($urandom_range(99) < recv_stall);

  task automatic send_req(bti_pkg::req_t r);
    while ($urandom_range(99) < sender_idle) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (req_stall);
    @(negedge clk);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_count(logic [8:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  function automatic bti_pkg::req_t load_req(int idx, logic [31:0] t, logic [31:0] v);
    bti_pkg::req_t r;
    r.opcode      = bti_pkg::OP_LOAD;
    r.point_index = idx[7:0];
    r.time_a      = t;
    r.time_b      = $urandom;
    r.load_value  = v;
    return r;
  endfunction

  task automatic load_point(int idx, logic [31:0] t, logic [31:0] v);
    tick_copy[idx] = t;
    send_req(load_req(idx, t, v));
  endtask

  task automatic load_table(int n, bit ordered);
    longint t;
    longint stepmax;
    t = ($urandom_range(3) == 0) ? 0 : $urandom_range(1000000);
    stepmax = (64'hFFFF_FFFF - t) / n;
    if ($urandom_range(1) && stepmax > 50) stepmax = 50;
    for (int i = 0; i < n; i++) begin
      load_point(i, ordered ? t[31:0] : $urandom, pick_value());
      t = t + $urandom_range(32'(stepmax), 1);
    end
  endtask

  function automatic logic [31:0] pick_tick(int n);
    logic [31:0] lo;
    logic [31:0] hi;
    lo = tick_copy[0];
    hi = tick_copy[n-1];
    case ($urandom_range(5))
      0: return $urandom;
      1: return tick_copy[$urandom_range(n-1)];
      2: return tick_copy[$urandom_range(n-1)] + $urandom_range(2) - 1;
      3: return $urandom_range(1) ? 32'h0 : 32'hFFFF_FFFF;
      default: return (lo < hi) ? $urandom_range(hi, lo) : $urandom;
    endcase
  endfunction

  function automatic bti_pkg::req_t query_req(int n);
    bti_pkg::req_t r;
    int            sel;
    logic [31:0]   a;
    logic [31:0]   b;
    r.point_index = 8'($urandom);
    r.time_a      = $urandom;
    r.time_b      = $urandom;
    r.load_value  = $urandom;
    sel = $urandom_range(99);
    if (sel < 45) begin
      r.opcode = bti_pkg::OP_EVAL;
      r.time_a = pick_tick(n);
    end else if (sel < 88) begin
      r.opcode = bti_pkg::OP_INTEGRATE;
      a = pick_tick(n);
      b = pick_tick(n);
      if ((a > b) != ($urandom_range(9) == 0)) begin
        r.time_a = b;
        r.time_b = a;
      end else begin
        r.time_a = a;
        r.time_b = b;
      end
    end else begin
      r.opcode = OP_UNUSED;
    end
    return r;
  endfunction

  task automatic random_items(int n, int count);
    int idx;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 8) begin
        // reloads inside the table may leave it unordered
        idx = ($urandom_range(1)) ? $urandom_range(n - 1) : $urandom_range(255);
        load_point(idx, $urandom, pick_value());
      end else begin
        send_req(query_req(n));
      end
    end
  endtask

  task automatic set_idling(int mode);
    case (mode % 4)
      0: begin sender_idle = 0;  recv_stall = 0;  end
      1: begin sender_idle = 57; recv_stall = 0;  end
      2: begin sender_idle = 0;  recv_stall = 57; end
      default: begin sender_idle = 31; recv_stall = 31; end
    endcase
  endtask

  task automatic big_phase(logic [8:0] cfg, bit full_span);
    bti_pkg::req_t r;
    int            k;
    write_count(cfg);
    load_table(256, 1'b1);
    for (int i = 0; i < 15; i++) begin
      r = query_req(256);
      r.opcode = bti_pkg::OP_EVAL;
      send_req(r);
    end
    for (int i = 0; i < 3; i++) begin
      k = $urandom_range(254);
      r = query_req(256);
      r.opcode = bti_pkg::OP_INTEGRATE;
      r.time_a = tick_copy[k];
      r.time_b = tick_copy[k+1];
      send_req(r);
    end
    if (full_span) begin
      r.opcode = bti_pkg::OP_INTEGRATE;
      r.time_a = 32'h0;
      r.time_b = 32'hFFFF_FFFF;
      send_req(r);
    end
  endtask

  int small_counts [14] = '{2, 0, 5, 8, 3, 1, 7, 4, 6, 2, 8, 5, 3, 4};

  initial begin
    bti_pkg::req_t r;
    int            n;
    rst         = 1'b1;
    req_valid   = 1'b0;
    req         = '0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    rsp_stall   = 1'b0;
    sender_idle = 0;
    recv_stall  = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: two points spanning the whole time axis at the value extremes
    write_count(9'd2);
    load_point(0, 32'h0, 32'h7FFF_FFFF);
    load_point(1, 32'hFFFF_FFFF, 32'h8000_0000);
    r = load_req(255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    r.time_b = 32'hFFFF_FFFF;
    tick_copy[255] = r.time_a;
    send_req(r);
    r = '0;
    foreach (tick_copy[i]) if (i < 2) begin
      r.opcode = bti_pkg::OP_EVAL;
      r.time_a = tick_copy[i];
      send_req(r);
    end
    r.opcode = bti_pkg::OP_EVAL;      r.time_a = 32'h8000_0000;  send_req(r);
    r.opcode = bti_pkg::OP_EVAL;      r.time_a = 32'h0000_0001;  send_req(r);
    r.opcode = bti_pkg::OP_INTEGRATE;
    r.time_a = 32'h0;          r.time_b = 32'hFFFF_FFFF; send_req(r);
    r.opcode = bti_pkg::OP_INTEGRATE;
    r.time_a = 32'd5;          r.time_b = 32'd5;         send_req(r);
    r.opcode = bti_pkg::OP_INTEGRATE;
    r.time_a = 32'hFFFF_FFFF;  r.time_b = 32'h0;         send_req(r);
    r.opcode = bti_pkg::OP_INTEGRATE;
    r.time_a = 32'h7FFF_FFFF;  r.time_b = 32'h8000_0001; send_req(r);
    r = '1;
    r.opcode = OP_UNUSED;
    send_req(r);
    load_point(0, 32'h0, 32'h7FFF_FFFF);
    load_point(1, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    r = '0;
    r.opcode = bti_pkg::OP_INTEGRATE; r.time_a = 32'h0; r.time_b = 32'hFFFF_FFFF; send_req(r);
    load_point(1, 32'hFFFF_FFFF, 32'h8000_0000);
    load_point(0, 32'h0, 32'h8000_0000);
    send_req(r);

    for (int p = 0; p < 14; p++) begin
      set_idling(p);
      n = (small_counts[p] < 1) ? 1 : small_counts[p];
      write_count(small_counts[p][8:0]);
      load_table(n, (p % 3) != 2);
      random_items(n, 80);
      if (p == 4) begin
        set_idling(p + 1);
        big_phase(9'd256, 1'b1);
      end
      if (p == 10) begin
        set_idling(p + 1);
        big_phase(9'd511, 1'b0);
      end
    end

    drain();
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/bti_pkg.sv
sv/breakpoint_table_interp_integrate.sv
tb/bti_table_checker.sv
tb/breakpoint_table_interp_integrate_tb.sv
